>>> src/sprt_pkg.sv
// Shared types and constants for the sorted peer ring table.
// Used by sprt_cell, sprt_ctrl and sorted_peer_ring_table; no dependencies.
package sprt_pkg;

  localparam int KEY_W   = 16;
  localparam int ID_W    = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_NBR    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Command token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic             act;        // token present
    op_t              op;
    logic [KEY_W-1:0] key;        // search key, or carried key on insert
    logic [ID_W-1:0]  id;         // carried id on insert
    logic             placed;     // insert: new entry already written
    logic             found;      // first match already seen
    logic [ID_W-1:0]  fid;        // id of the match
    logic             need_next;  // match seen, next neighbor not yet taken
    logic             at_head;    // match sits in cell 0
    logic [KEY_W-1:0] hk;         // head entry
    logic [ID_W-1:0]  hid;
    logic [KEY_W-1:0] lk;         // last live entry passed
    logic [ID_W-1:0]  lid;
    logic [KEY_W-1:0] pk;         // previous neighbor of the match
    logic [ID_W-1:0]  pid;
    logic [KEY_W-1:0] nk;         // next neighbor of the match
    logic [ID_W-1:0]  nid;
  } tok_t;

endpackage

>>> src/sorted_peer_ring_table.sv
// Top level of the sorted peer ring table: control plus a chain of table cells.
// Depends on sprt_pkg, sprt_ctrl and sprt_cell.
//
// The table holds up to CAPACITY (key, peer id) entries in ascending key order,
// a new entry going in front of equal keys. Each command is one transfer on the
// input channel and yields exactly one transfer on the output channel. Clear,
// unknown command codes, insert into a full table and find/remove/neighbors on an
// empty table answer directly, the result appearing in the cycle after accept.
// Insert, find, remove and neighbors otherwise send a command token down the
// chain of cells, one cell per cycle, so the chain length sets how long they
// take; the result is loaded once the token has left the last cell and the output
// register is free, and only then is the next command accepted. A new command is
// accepted only once the output register is empty or hands its result over in the
// same cycle; a result held by a stalled receiver holds the input off.
// Entries beyond the current count are never read, so the table needs no clear
// pass after reset.
module sorted_peer_ring_table import sprt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   key,
  input  logic [ID_W-1:0]    peer_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count,
  output logic [ID_W-1:0]    found_id,
  output logic [KEY_W-1:0]   prev_key,
  output logic [ID_W-1:0]    prev_id,
  output logic [KEY_W-1:0]   next_key,
  output logic [ID_W-1:0]    next_id
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]    cnt;
  tok_t             toks   [CAPACITY+1];
  logic [KEY_W-1:0] keys   [CAPACITY];
  logic [ID_W-1:0]  ids    [CAPACITY];

  // Sequencer: holds the count, launches tokens and forms results.
  sprt_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .key       (key),
    .peer_id   (peer_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .count     (count),
    .found_id  (found_id),
    .prev_key  (prev_key),
    .prev_id   (prev_id),
    .next_key  (next_key),
    .next_id   (next_id),
    .cnt       (cnt),
    .tok       (toks[0]),
    .ret       (toks[CAPACITY])
  );

  // Cell chain: cell i holds entry i; the token advances one cell per cycle.
  // On remove a cell pulls its right neighbor; the last cell keeps its own.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int R = (i + 1 < CAPACITY) ? i + 1 : i;
    sprt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cnt       (cnt),
      .tok_i     (toks[i]),
      .right_key (keys[R]),
      .right_id  (ids[R]),
      .tok       (toks[i+1]),
      .key       (keys[i]),
      .id        (ids[i])
    );
  end

endmodule

>>> src/sprt_cell.sv
// One table slot of the sorted peer ring table, plus its stage of the token chain.
// Depends on sprt_pkg.
module sprt_cell import sprt_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CW-1:0]    cnt,
  input  tok_t             tok_i,
  input  logic [KEY_W-1:0] right_key,
  input  logic [ID_W-1:0]  right_id,
  output tok_t             tok,
  output logic [KEY_W-1:0] key,
  output logic [ID_W-1:0]  id
);

  tok_t             tok_next;
  logic [KEY_W-1:0] key_next;
  logic [ID_W-1:0]  id_next;
  logic             live;
  logic             match;
  logic             swap;

  assign live = (CW'(IDX) < cnt);

  always_comb begin
    tok_next = tok_i;
    key_next = key;
    id_next  = id;
    match    = 1'b0;
    swap     = 1'b0;
    if (tok_i.act) begin
      case (tok_i.op)
        OP_INSERT: begin
          // take the carried entry at the first slot not below it, then ripple
          // up to and including the first free slot
          swap = tok_i.placed ? (CW'(IDX) <= cnt) : (!live || (key >= tok_i.key));
          if (swap) begin
            key_next        = tok_i.key;
            id_next         = tok_i.id;
            tok_next.key    = key;
            tok_next.id     = id;
            tok_next.placed = 1'b1;
          end
        end
        OP_FIND, OP_REMOVE, OP_NBR: begin
          if (live) begin
            match = !tok_i.found && (key == tok_i.key);
            if (match) begin
              tok_next.found     = 1'b1;
              tok_next.fid       = id;
              tok_next.pk        = tok_i.lk;
              tok_next.pid       = tok_i.lid;
              tok_next.at_head   = (IDX == 0);
              tok_next.need_next = 1'b1;
            end else if (tok_i.need_next) begin
              tok_next.nk        = key;
              tok_next.nid       = id;
              tok_next.need_next = 1'b0;
            end
            if (IDX == 0) begin
              tok_next.hk  = key;
              tok_next.hid = id;
            end
            tok_next.lk  = key;
            tok_next.lid = id;
            // close the gap: pull the right neighbor, not yet touched by the token
            if ((tok_i.op == OP_REMOVE) && (tok_i.found || match)) begin
              key_next = right_key;
              id_next  = right_id;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.act <= 1'b0;
    end else begin
      tok.act <= tok_next.act;
    end
    tok.op        <= tok_next.op;
    tok.key       <= tok_next.key;
    tok.id        <= tok_next.id;
    tok.placed    <= tok_next.placed;
    tok.found     <= tok_next.found;
    tok.fid       <= tok_next.fid;
    tok.need_next <= tok_next.need_next;
    tok.at_head   <= tok_next.at_head;
    tok.hk        <= tok_next.hk;
    tok.hid       <= tok_next.hid;
    tok.lk        <= tok_next.lk;
    tok.lid       <= tok_next.lid;
    tok.pk        <= tok_next.pk;
    tok.pid       <= tok_next.pid;
    tok.nk        <= tok_next.nk;
    tok.nid       <= tok_next.nid;
    key           <= key_next;
    id            <= id_next;
  end

endmodule

>>> src/sprt_ctrl.sv
// Command sequencer, entry count and result register of the sorted peer ring table.
// Depends on sprt_pkg; drives the head of the sprt_cell chain and takes its tail.
module sprt_ctrl import sprt_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   key,
  input  logic [ID_W-1:0]    peer_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count,
  output logic [ID_W-1:0]    found_id,
  output logic [KEY_W-1:0]   prev_key,
  output logic [ID_W-1:0]    prev_id,
  output logic [KEY_W-1:0]   next_key,
  output logic [ID_W-1:0]    next_id,
  output logic [CW-1:0]      cnt,
  output tok_t               tok,
  input  tok_t               ret
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state, state_next;
  tok_t             fin;
  tok_t             tok_next;
  logic [CW-1:0]    cnt_next;
  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             launch;
  status_t          res_status;
  logic [ID_W-1:0]  res_fid;
  logic [KEY_W-1:0] res_pk;
  logic [ID_W-1:0]  res_pid;
  logic [KEY_W-1:0] res_nk;
  logic [ID_W-1:0]  res_nid;

  assign out_free = !(out_valid && out_stall);
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    launch     = 1'b0;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_fid    = '0;
    res_pk     = '0;
    res_pid    = '0;
    res_nk     = '0;
    res_nid    = '0;
    tok_next           = '0;
    tok_next.op        = op_t'(command);
    tok_next.key       = key;
    tok_next.id        = peer_id;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(command))
            OP_INSERT: begin
              if (cnt == CW'(CAPACITY)) begin
                res_status = ST_FULL;
                out_load   = 1'b1;
              end else begin
                launch = 1'b1;
              end
            end
            OP_FIND, OP_REMOVE, OP_NBR: begin
              if (cnt == '0) begin
                res_status = ST_EMPTY;
                out_load   = 1'b1;
              end else begin
                launch = 1'b1;
              end
            end
            OP_CLEAR: begin
              cnt_next = '0;
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
          if (launch) begin
            tok_next.act = 1'b1;
            state_next   = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (ret.act) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (fin.op == OP_INSERT) begin
            cnt_next = cnt + 1'b1;
          end else if (!fin.found) begin
            res_status = ST_MISSING;
          end else begin
            res_fid = fin.fid;
            if (fin.op == OP_REMOVE) begin
              cnt_next = cnt - 1'b1;
            end else if (fin.op == OP_NBR) begin
              // ring wrap: head match takes the tail, last match takes the head
              res_pk  = fin.at_head ? fin.lk : fin.pk;
              res_pid = fin.at_head ? fin.lid : fin.pid;
              res_nk  = fin.need_next ? fin.hk : fin.nk;
              res_nid = fin.need_next ? fin.hid : fin.nid;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.act <= 1'b0;
    end else begin
      tok.act <= tok_next.act;
    end
    tok.op        <= tok_next.op;
    tok.key       <= tok_next.key;
    tok.id        <= tok_next.id;
    tok.placed    <= tok_next.placed;
    tok.found     <= tok_next.found;
    tok.fid       <= tok_next.fid;
    tok.need_next <= tok_next.need_next;
    tok.at_head   <= tok_next.at_head;
    tok.hk        <= tok_next.hk;
    tok.hid       <= tok_next.hid;
    tok.lk        <= tok_next.lk;
    tok.lid       <= tok_next.lid;
    tok.pk        <= tok_next.pk;
    tok.pid       <= tok_next.pid;
    tok.nk        <= tok_next.nk;
    tok.nid       <= tok_next.nid;
    if (state == S_RUN && ret.act) begin
      fin <= ret;
    end
    if (out_load) begin
      status   <= res_status;
      count    <= COUNT_W'(cnt_next);
      found_id <= res_fid;
      prev_key <= res_pk;
      prev_id  <= res_pid;
      next_key <= res_nk;
      next_id  <= res_nid;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    (cnt != $past(cnt)) |-> $past(out_load))
    else $error("entry count changed without a result");

  a_no_result_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (!out_load && in_stall))
    else $error("result or transfer while a token is in the chain");

  a_done_after_return: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_DONE) |-> $past(ret.act))
    else $error("finish without a returning token");

endmodule

>>> tb/sprt_table_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted peer ring table: watches both channels, keeps its own
// copy of the table and compares every result transfer. Depends on sprt_pkg.
module sprt_table_checker import sprt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   key,
  input  logic [ID_W-1:0]    peer_id,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [COUNT_W-1:0] count,
  input  logic [ID_W-1:0]    found_id,
  input  logic [KEY_W-1:0]   prev_key,
  input  logic [ID_W-1:0]    prev_id,
  input  logic [KEY_W-1:0]   next_key,
  input  logic [ID_W-1:0]    next_id,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    status_t            st;
    logic [COUNT_W-1:0] cnt;
    logic [ID_W-1:0]    fid;
    logic [KEY_W-1:0]   pk;
    logic [ID_W-1:0]    pid;
    logic [KEY_W-1:0]   nk;
    logic [ID_W-1:0]    nid;
  } table_reply_t;

  table_reply_t     reply_q[$];
  logic [KEY_W-1:0] tbl_key [CAPACITY];
  logic [ID_W-1:0]  tbl_id  [CAPACITY];
  int               live;

  // Apply one command to the shadow table and return the reply it should give.
  function automatic table_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [ID_W-1:0]  id);
    table_reply_t r;
    int pos;
    int j;
    int p;
    int n;
    r = '0;
    r.st = ST_OK;
    case (cmd)
      OP_INSERT: begin
        if (live >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < live && tbl_key[pos] < k) pos++;
          for (j = live; j > pos; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_id[j]  = tbl_id[j-1];
          end
          tbl_key[pos] = k;
          tbl_id[pos]  = id;
          live++;
        end
      end
      OP_FIND, OP_REMOVE, OP_NBR: begin
        if (live == 0) begin
          r.st = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < live && tbl_key[pos] != k) pos++;
          if (pos >= live) begin
            r.st = ST_MISSING;
          end else begin
            r.fid = tbl_id[pos];
            if (cmd == OP_REMOVE) begin
              for (j = pos; j + 1 < live; j++) begin
                tbl_key[j] = tbl_key[j+1];
                tbl_id[j]  = tbl_id[j+1];
              end
              live--;
            end else if (cmd == OP_NBR) begin
              p = (pos == 0) ? live - 1 : pos - 1;
              n = (pos + 1 >= live) ? 0 : pos + 1;
              r.pk  = tbl_key[p];
              r.pid = tbl_id[p];
              r.nk  = tbl_key[n];
              r.nid = tbl_id[n];
            end
          end
        end
      end
      OP_CLEAR: live = 0;
      default: ;
    endcase
    r.cnt = COUNT_W'(live);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ID_W-1:0] exp_v,
                             input logic [ID_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Retire the result first: a command accepted at this edge cannot have its
  // reply at the same edge.
  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      live = 0;
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result transfer with no command pending, status %h count %h",
                   $time, status, count);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("status",   ID_W'(want.st),  ID_W'(status));
          check_field("count",    ID_W'(want.cnt), ID_W'(count));
          check_field("found_id", want.fid,        found_id);
          check_field("prev_key", ID_W'(want.pk),  ID_W'(prev_key));
          check_field("prev_id",  want.pid,        prev_id);
          check_field("next_key", ID_W'(want.nk),  ID_W'(next_key));
          check_field("next_id",  want.nid,        next_id);
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(apply_command(command, key, peer_id));
    end
    outstanding = reply_q.size();
  end

endmodule

>>> tb/sorted_peer_ring_table_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sorted peer ring table: clock, reset, stimulus, verdict.
// Depends on sprt_pkg, sorted_peer_ring_table and sprt_table_checker.
module sorted_peer_ring_table_tb;
  import sprt_pkg::*;

  localparam int CAP             = 64;
  localparam int ITEM_TARGET     = 1300;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int RECENT_DEPTH    = 32;
  // Command codes the block ignores.
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  typedef enum {MIX_FILL, MIX_BLEND, MIX_DRAIN} mix_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command   = OP_INSERT;
  logic [KEY_W-1:0]   key       = '0;
  logic [ID_W-1:0]    peer_id   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [COUNT_W-1:0] count;
  logic [ID_W-1:0]    found_id;
  logic [KEY_W-1:0]   prev_key;
  logic [ID_W-1:0]    prev_id;
  logic [KEY_W-1:0]   next_key;
  logic [ID_W-1:0]    next_id;
  int                 fail_count;
  int                 outstanding;

  // Sender bookkeeping: remaining transfers in the current burst, items issued
  // so far, and a ring of recently inserted keys so lookups mostly hit.
  int               burst_left = 0;
  int               items_sent = 0;
  logic [KEY_W-1:0] recent_keys [RECENT_DEPTH];
  int               recent_n = 0;

  always #4 clk = ~clk;

  sorted_peer_ring_table #(.CAPACITY(CAP)) DUT (
    .clk, .rst, .in_valid, .in_stall, .command, .key, .peer_id,
    .out_valid, .out_stall, .status, .count, .found_id,
    .prev_key, .prev_id, .next_key, .next_id
  );

  sprt_table_checker #(.CAPACITY(CAP)) table_check (
    .clk, .rst, .in_valid, .in_stall, .command, .key, .peer_id,
    .out_valid, .out_stall, .status, .count, .found_id,
    .prev_key, .prev_id, .next_key, .next_id,
    .fail_count, .outstanding
  );

  // Offer one command and hold it until the block takes it. At the start of a
  // burst, drop valid for a random gap first (sometimes none at all).
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                          input logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    peer_id  <= id;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and hold until every pending result has come back.
  task automatic await_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Insert keys: a tight low pool for duplicates, the top of the range, and
  // fully random keys. Remember each one for later lookups.
  function automatic logic [KEY_W-1:0] insert_key();
    logic [KEY_W-1:0] k;
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)       k = KEY_W'($urandom_range(0, 11));
    else if (r == 3) k = 16'hFFFF - KEY_W'($urandom_range(0, 3));
    else             k = KEY_W'($urandom);
    recent_keys[recent_n % RECENT_DEPTH] = k;
    recent_n++;
    return k;
  endfunction

  // Lookup keys: mostly a recently inserted key, otherwise anything.
  function automatic logic [KEY_W-1:0] lookup_key();
    int span;
    span = (recent_n < RECENT_DEPTH) ? recent_n : RECENT_DEPTH;
    if (span > 0 && $urandom_range(0, 9) < 8)
      return recent_keys[$urandom_range(0, span - 1)];
    return KEY_W'($urandom);
  endfunction

  // Command weights per mix: fill pushes the table to full, drain empties it.
  function automatic logic [CMD_W-1:0] pick_op(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 85)      return OP_INSERT;
        else if (r < 90) return OP_FIND;
        else if (r < 95) return OP_NBR;
        else             return OP_REMOVE;
      end
      MIX_DRAIN: begin
        if (r < 70)      return OP_REMOVE;
        else if (r < 80) return OP_FIND;
        else if (r < 90) return OP_NBR;
        else             return OP_INSERT;
      end
      default: begin
        if (r < 35)      return OP_INSERT;
        else if (r < 55) return OP_FIND;
        else if (r < 75) return OP_REMOVE;
        else if (r < 97) return OP_NBR;
        else             return OP_CLEAR;
      end
    endcase
  endfunction

  // One random item; ignored codes are sprinkled in but not counted.
  task automatic send_random(input mix_t mix);
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 99) < 3) begin
      send_cmd(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), KEY_W'($urandom), $urandom);
    end else begin
      op = pick_op(mix);
      k  = (op == OP_INSERT) ? insert_key() : lookup_key();
      send_cmd(op, k, $urandom);
      items_sent++;
    end
  endtask

  // Receiver: segments of different stall behavior, each output change at a
  // falling edge. Two segments are long hold-offs so the table backs up and
  // stalls its input while the sender keeps offering.
  initial begin : receiver
    int seg;
    int seg_len;
    int cyc;
    stall_mode_t mode;
    seg = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      seg++;
      if (seg == 6 || seg == 30) begin
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        seg_len = $urandom_range(20, 300);
        mode    = stall_mode_t'($urandom_range(0, 3));
        for (cyc = 0; cyc < seg_len; cyc++) begin
          @(negedge clk);
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
            default:     out_stall <= (cyc % 4 == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    mix_t mix;
    int   span;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lookups on an empty table.
    send_cmd(OP_FIND,   16'h1234, 32'h0);
    send_cmd(OP_REMOVE, 16'h0000, 32'h0);
    send_cmd(OP_NBR,    16'hFFFF, 32'h0);
    // Single entry: both ring neighbors are the entry itself.
    send_cmd(OP_INSERT, 16'h0000, 32'h0000_0000);
    send_cmd(OP_NBR,    16'h0000, 32'h0);
    // Extremes, and a duplicate key that must land in front of the first.
    send_cmd(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(OP_INSERT, 16'h8000, 32'hAAAA_5555);
    send_cmd(OP_INSERT, 16'h8000, 32'h5555_AAAA);
    send_cmd(OP_FIND,   16'h8000, 32'h0);
    // Wrap at the head, wrap at the tail, and a middle entry.
    send_cmd(OP_NBR,    16'h0000, 32'h0);
    send_cmd(OP_NBR,    16'hFFFF, 32'h0);
    send_cmd(OP_NBR,    16'h8000, 32'h0);
    // Missing keys, and removal of the front duplicate only.
    send_cmd(OP_FIND,   16'h0001, 32'h0);
    send_cmd(OP_REMOVE, 16'h8000, 32'h0);
    send_cmd(OP_FIND,   16'h8000, 32'h0);
    send_cmd(OP_REMOVE, 16'h7FFF, 32'h0);
    // Unused codes leave the table alone.
    send_cmd(CMD_RSVD_LO,                16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_W'(CMD_RSVD_LO + 3'd1), 16'h0000, 32'h0);
    send_cmd(CMD_RSVD_HI,                16'h8000, 32'h1234_5678);
    // Clear, then use the table again.
    send_cmd(OP_CLEAR,  16'h0000, 32'h0);
    send_cmd(OP_FIND,   16'h0000, 32'h0);
    send_cmd(OP_INSERT, 16'h1234, 32'hDEAD_BEEF);
    send_cmd(OP_FIND,   16'h1234, 32'h0);
    await_drain();

    // Random phases; sometimes pause until the block has answered everything.
    while (items_sent < ITEM_TARGET) begin
      mix  = mix_t'($urandom_range(0, 2));
      span = $urandom_range(40, 120);
      repeat (span) send_random(mix);
      if ($urandom_range(0, 3) == 0) await_drain();
    end

    // Drain, then allow one more walk down the chain for stray results.
    await_drain();
    repeat (CAP + 16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
